[hw/rtl/kmeans_lloyd_clustering_core_defines.svh]
// assertion macros for the port-level checker
`ifndef KMEANS_LLOYD_CLUSTERING_CORE_DEFINES_SVH
`define KMEANS_LLOYD_CLUSTERING_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define KMLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmlc checker: same-cycle rule broken");

// next-cycle implication, clocked on clk, quiet during reset
`define KMLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmlc checker: next-cycle rule broken");

`endif

[hw/rtl/kmlc_pkg.sv]
// shared types and constants of the k-means core
package kmlc_pkg;

  localparam int COORD_W = 32;
  localparam int CL_W    = 6;
  localparam int DIST_W  = 2 * COORD_W + 6;

  localparam logic [1:0] CMD_LOAD_POINT    = 2'd0;
  localparam logic [1:0] CMD_LOAD_CENTROID = 2'd1;
  localparam logic [1:0] CMD_RUN           = 2'd2;

  localparam logic [1:0] REG_ITERATIONS = 2'd0;
  localparam logic [1:0] REG_CLUSTERS   = 2'd1;
  localparam logic [1:0] REG_DIMENSIONS = 2'd2;
  localparam logic [1:0] REG_POINTS     = 2'd3;

  typedef struct packed {
    logic            vld;
    logic            first_cl;
    logic            first_d;
    logic            last_d;
    logic [CL_W-1:0] cl;
  } tag_t;

endpackage

[hw/rtl/kmeans_lloyd_clustering_core.sv]
// top level of the lloyd k-means core: sequencer, stores and config
// load requests are taken while idle; a load leaves the block idle and ready
// a run is paced by the shared distance pipeline and the bit-serial divider, then emits
//   each centroid coordinate in turn, holding it while out_stall is high
// rst_n is synchronous, active low; config returns to its defaults, stores stay undefined
module kmeans_lloyd_clustering_core #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_DIMS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_entry_index,
  input  logic [2:0]  in_coord_index,
  input  logic signed [31:0] in_coord_value,
  // result request channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_centroid_index,
  output logic [2:0]  out_coord_index,
  output logic signed [31:0] out_value,
  output logic        out_last,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW    = kmlc_pkg::COORD_W;
  localparam int PD    = MAX_POINTS * MAX_DIMS;
  localparam int CD    = MAX_CLUSTERS * MAX_DIMS;
  localparam int PA_W  = $clog2(PD);
  localparam int CA_W  = $clog2(CD);
  localparam int PI_W  = $clog2(MAX_POINTS);
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int JI_W  = $clog2(MAX_CLUSTERS);
  localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SUM_W = CW + PI_W + 1;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_CLR       = 13'b0000000000010,
    ST_DIST      = 13'b0000000000100,
    ST_DRAIN     = 13'b0000000001000,
    ST_ACC_RD    = 13'b0000000010000,
    ST_ACC_WR    = 13'b0000000100000,
    ST_UPD_CHK   = 13'b0000001000000,
    ST_UPD_RD    = 13'b0000010000000,
    ST_UPD_DIV   = 13'b0000100000000,
    ST_UPD_WAIT  = 13'b0001000000000,
    ST_EMIT_RD   = 13'b0010000000000,
    ST_EMIT_LD   = 13'b0100000000000,
    ST_EMIT_HOLD = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [9:0]  cfg_iter_r;
  logic [3:0]  cfg_k_r;
  logic [3:0]  cfg_dims_r;
  logic [10:0] cfg_np_r;

  // loop counters
  logic [9:0]      iter_r, iter_nxt;
  logic [PI_W-1:0] p_r, p_nxt;
  logic [JI_W-1:0] j_r, j_nxt;
  logic [DI_W-1:0] d_r, d_nxt;
  logic [CA_W-1:0] clr_r, clr_nxt;
  logic            neg_r, neg_nxt;

  // per-cluster member counts
  logic [PC_W-1:0] members_r [MAX_CLUSTERS];
  logic            mem_clr, mem_inc;
  logic [JI_W-1:0] cnt_sel;
  logic [PC_W-1:0] cnt_cur;

  // derived loop bounds
  logic [JI_W-1:0] k_m1;
  logic [DI_W-1:0] dims_m1;
  logic [PI_W-1:0] np_m1;
  logic            np_zero;
  logic            last_d, last_j;

  // output registers
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_cl_r, out_cd_r;
  logic [CW-1:0]   out_val_r;
  logic            out_last_r;
  logic            out_load;

  // stores
  logic            pt_we;
  logic [PA_W-1:0] pt_waddr, pt_raddr;
  logic [CW-1:0]   pt_rd;
  logic            ce_we;
  logic [CA_W-1:0] ce_waddr, ce_raddr;
  logic [CW-1:0]   ce_wdata, ce_rd;
  logic            sm_we;
  logic [CA_W-1:0] sm_waddr, sm_raddr;
  logic [SUM_W-1:0] sm_wdata, sm_rd;

  // shared units
  kmlc_pkg::tag_t            tag;
  logic                      dist_busy;
  logic [kmlc_pkg::CL_W-1:0] best_cl;
  logic [JI_W-1:0]           bj;
  logic                      div_start, div_done;
  logic [SUM_W-1:0]          div_q, sm_mag, q_signed;

  logic in_acc;
  logic load_ok_pt, load_ok_ce;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign bj       = JI_W'(best_cl);

  // config writes, masked to the register widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_iter_r <= 10'd1;
      cfg_k_r    <= 4'd2;
      cfg_dims_r <= 4'd2;
      cfg_np_r   <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmlc_pkg::REG_ITERATIONS: cfg_iter_r <= cfg_data[9:0];
        kmlc_pkg::REG_CLUSTERS:   cfg_k_r    <= cfg_data[3:0];
        kmlc_pkg::REG_DIMENSIONS: cfg_dims_r <= cfg_data[3:0];
        kmlc_pkg::REG_POINTS:     cfg_np_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // clamp counts: zero k or dims acts as one, large values saturate to the store size
  always_comb begin
    if (cfg_k_r == 4'd0) begin
      k_m1 = '0;
    end else if (32'(cfg_k_r) > MAX_CLUSTERS) begin
      k_m1 = JI_W'(MAX_CLUSTERS - 1);
    end else begin
      k_m1 = JI_W'(cfg_k_r - 4'd1);
    end
    if (cfg_dims_r == 4'd0) begin
      dims_m1 = '0;
    end else if (32'(cfg_dims_r) > MAX_DIMS) begin
      dims_m1 = DI_W'(MAX_DIMS - 1);
    end else begin
      dims_m1 = DI_W'(cfg_dims_r - 4'd1);
    end
    np_zero = (cfg_np_r == 11'd0);
    if (32'(cfg_np_r) > MAX_POINTS) begin
      np_m1 = PI_W'(MAX_POINTS - 1);
    end else begin
      np_m1 = PI_W'(cfg_np_r - 11'd1);
    end
  end

  assign last_d = (d_r == dims_m1);
  assign last_j = (j_r == k_m1);

  // load requests outside the stores are dropped
  assign load_ok_pt = (32'(in_entry_index) < MAX_POINTS) && (32'(in_coord_index) < MAX_DIMS);
  assign load_ok_ce = (32'(in_entry_index) < MAX_CLUSTERS) && (32'(in_coord_index) < MAX_DIMS);

  // member count read port: best cluster while accumulating, else the update index
  assign cnt_sel = (state_r == ST_ACC_WR) ? bj : j_r;
  assign cnt_cur = members_r[cnt_sel];

  // sign and magnitude of the cluster sum for the divider
  assign sm_mag   = sm_rd[SUM_W-1] ? (~sm_rd + 1'b1) : sm_rd;
  assign q_signed = neg_r ? (~div_q + 1'b1) : div_q;

  // point store
  assign pt_we    = in_acc && (in_cmd == kmlc_pkg::CMD_LOAD_POINT) && load_ok_pt;
  assign pt_waddr = PA_W'(PA_W'(in_entry_index) * PA_W'(MAX_DIMS) + PA_W'(in_coord_index));
  assign pt_raddr = PA_W'(PA_W'(p_r) * PA_W'(MAX_DIMS) + PA_W'(d_r));

  // centroid store: loads when idle, new means during the update pass
  always_comb begin
    ce_raddr = CA_W'(CA_W'(j_r) * CA_W'(MAX_DIMS) + CA_W'(d_r));
    if (state_r == ST_IDLE) begin
      ce_we    = in_acc && (in_cmd == kmlc_pkg::CMD_LOAD_CENTROID) && load_ok_ce;
      ce_waddr = CA_W'(CA_W'(in_entry_index) * CA_W'(MAX_DIMS) + CA_W'(in_coord_index));
      ce_wdata = in_coord_value;
    end else begin
      ce_we    = (state_r == ST_UPD_WAIT) && div_done;
      ce_waddr = ce_raddr;
      ce_wdata = q_signed[CW-1:0];
    end
  end

  // sum store: cleared by a sweep, accumulated per point, read back for the update
  always_comb begin
    sm_raddr = (state_r == ST_ACC_RD || state_r == ST_ACC_WR)
             ? CA_W'(CA_W'(bj) * CA_W'(MAX_DIMS) + CA_W'(d_r))
             : CA_W'(CA_W'(j_r) * CA_W'(MAX_DIMS) + CA_W'(d_r));
    if (state_r == ST_CLR) begin
      sm_we    = 1'b1;
      sm_waddr = clr_r;
      sm_wdata = '0;
    end else begin
      sm_we    = (state_r == ST_ACC_WR);
      sm_waddr = sm_raddr;
      sm_wdata = sm_rd + {{(SUM_W-CW){pt_rd[CW-1]}}, pt_rd};
    end
  end

  // distance tag for the request issued this cycle
  always_comb begin
    tag          = '0;
    tag.vld      = (state_r == ST_DIST);
    tag.first_cl = (j_r == '0);
    tag.first_d  = (d_r == '0);
    tag.last_d   = last_d;
    tag.cl       = kmlc_pkg::CL_W'(j_r);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    d_nxt         = d_r;
    clr_nxt       = clr_r;
    neg_nxt       = neg_r;
    mem_clr       = 1'b0;
    mem_inc       = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd == kmlc_pkg::CMD_RUN) begin
          j_nxt    = '0;
          d_nxt    = '0;
          iter_nxt = '0;
          clr_nxt  = '0;
          // zero rounds goes straight to emitting the loaded centroids
          state_nxt = (cfg_iter_r == 10'd0) ? ST_EMIT_RD : ST_CLR;
        end
      end
      ST_CLR: begin
        mem_clr = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CA_W'(CD - 1)) begin
          p_nxt = '0;
          j_nxt = '0;
          d_nxt = '0;
          // no points: every cluster is empty and keeps its centroid
          state_nxt = np_zero ? ST_UPD_CHK : ST_DIST;
        end
      end
      ST_DIST: begin
        if (last_d) begin
          d_nxt = '0;
          if (last_j) begin
            state_nxt = ST_DRAIN;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!dist_busy) begin
          d_nxt     = '0;
          state_nxt = ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        state_nxt = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        if (last_d) begin
          mem_inc = 1'b1;
          j_nxt   = '0;
          d_nxt   = '0;
          if (p_r == np_m1) begin
            state_nxt = ST_UPD_CHK;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = ST_DIST;
          end
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_ACC_RD;
        end
      end
      ST_UPD_CHK: begin
        d_nxt = '0;
        if (cnt_cur != '0) begin
          state_nxt = ST_UPD_RD;
        end else if (!last_j) begin
          j_nxt = j_r + 1'b1;
        end else if (iter_r == cfg_iter_r - 10'd1) begin
          j_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_DIV;
      end
      ST_UPD_DIV: begin
        div_start = 1'b1;
        neg_nxt   = sm_rd[SUM_W-1];
        state_nxt = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        if (div_done) begin
          if (last_d) begin
            d_nxt = '0;
            if (!last_j) begin
              j_nxt     = j_r + 1'b1;
              state_nxt = ST_UPD_CHK;
            end else if (iter_r == cfg_iter_r - 10'd1) begin
              j_nxt     = '0;
              state_nxt = ST_EMIT_RD;
            end else begin
              iter_nxt  = iter_r + 1'b1;
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
          end else begin
            d_nxt     = d_r + 1'b1;
            state_nxt = ST_UPD_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (last_d && last_j) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
            if (last_d) begin
              d_nxt = '0;
              j_nxt = j_r + 1'b1;
            end else begin
              d_nxt = d_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      p_r         <= '0;
      j_r         <= '0;
      d_r         <= '0;
      clr_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
      p_r         <= p_nxt;
      j_r         <= j_nxt;
      d_r         <= d_nxt;
      clr_r       <= clr_nxt;
      neg_r       <= neg_nxt;
    end
  end

  // member counts, cleared at the start of every round
  always_ff @(posedge clk) begin
    if (mem_clr) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        members_r[i] <= '0;
      end
    end else if (mem_inc) begin
      members_r[bj] <= cnt_cur + 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cl_r   <= 3'(j_r);
      out_cd_r   <= 3'(d_r);
      out_val_r  <= ce_rd;
      out_last_r <= last_d && last_j;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_centroid_index = out_cl_r;
  assign out_coord_index    = out_cd_r;
  assign out_value          = out_val_r;
  assign out_last           = out_last_r;

  kmlc_ram #(.WIDTH(CW), .DEPTH(PD)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (in_coord_value),
    .raddr (pt_raddr),
    .rdata (pt_rd)
  );

  kmlc_ram #(.WIDTH(CW), .DEPTH(CD)) u_ce_ram (
    .clk   (clk),
    .we    (ce_we),
    .waddr (ce_waddr),
    .wdata (ce_wdata),
    .raddr (ce_raddr),
    .rdata (ce_rd)
  );

  kmlc_ram #(.WIDTH(SUM_W), .DEPTH(CD)) u_sum_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (sm_raddr),
    .rdata (sm_rd)
  );

  kmlc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag),
    .pt_data (pt_rd),
    .ce_data (ce_rd),
    .busy    (dist_busy),
    .best_cl (best_cl)
  );

  kmlc_div #(.N(SUM_W), .D(PC_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sm_mag),
    .divisor  (cnt_cur),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

[hw/rtl/kmlc_ram.sv]
// generic single write, single read ram with registered read data
module kmlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kmlc_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module kmlc_div #(
  parameter int N = 43,
  parameter int D = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  quot_r, quot_nxt;
  logic [D-1:0]  rem_r, rem_nxt;
  logic [D-1:0]  div_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [D:0]    trial;
  logic [D:0]    diff;

  always_comb begin
    trial    = {rem_r, quot_r[N-1]};
    diff     = trial - {1'b0, div_r};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[D]) begin
        rem_nxt  = diff[D-1:0];
        quot_nxt = {quot_r[N-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[D-1:0];
        quot_nxt = {quot_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

[hw/rtl/kmlc_dist.sv]
// distance pipeline: abs difference, square, accumulate, nearest search
module kmlc_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmlc_pkg::tag_t                tag_in,
  input  logic [kmlc_pkg::COORD_W-1:0]  pt_data,
  input  logic [kmlc_pkg::COORD_W-1:0]  ce_data,
  output logic                          busy,
  output logic [kmlc_pkg::CL_W-1:0]     best_cl
);

  localparam int CW = kmlc_pkg::COORD_W;
  localparam int DW = kmlc_pkg::DIST_W;

  kmlc_pkg::tag_t s1_tag_r, s2_tag_r, s3_tag_r;
  logic [CW-1:0]   diff_r;
  logic [2*CW-1:0] prod_r;
  logic [DW-1:0]   acc_r, best_r, dist_sum;
  logic [CW:0]     sdiff;
  logic [CW:0]     mag;
  logic [kmlc_pkg::CL_W-1:0] best_cl_r;

  always_comb begin
    sdiff    = {pt_data[CW-1], pt_data} - {ce_data[CW-1], ce_data};
    mag      = sdiff[CW] ? (~sdiff + 1'b1) : sdiff;
    dist_sum = (s3_tag_r.first_d ? '0 : acc_r) + DW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
    diff_r <= mag[CW-1:0];
    prod_r <= diff_r * diff_r;
    if (s3_tag_r.vld) begin
      acc_r <= dist_sum;
      // strict compare keeps the lowest index on a tie
      if (s3_tag_r.last_d && (s3_tag_r.first_cl || dist_sum < best_r)) begin
        best_r    <= dist_sum;
        best_cl_r <= s3_tag_r.cl;
      end
    end
  end

  assign busy    = s1_tag_r.vld | s2_tag_r.vld | s3_tag_r.vld;
  assign best_cl = best_cl_r;

endmodule

[hw/rtl/kmlc_checker.sv]
// port-level checker for the k-means core, bound to the top level
`include "kmeans_lloyd_clustering_core_defines.svh"

module kmlc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_last,
  input logic [31:0] out_value
);

  `KMLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value))
  `KMLC_ASSERT_IMPL(a_busy_emit, out_valid, in_stall)
  `KMLC_ASSERT_NEXT(a_more_after, out_valid && !out_stall && !out_last, in_stall)

endmodule

bind kmeans_lloyd_clustering_core kmlc_checker u_kmlc_checker (.*);
